// ===== rtl/atp_pkg.sv =====
package atp_pkg;

    localparam int NUM_COMMANDS = 6;
    localparam int NAME_CHARS   = 8;
    localparam int MAX_PARAMS   = 8;

    localparam int NAME_W     = 8 * NAME_CHARS;
    localparam int NAME_IDX_W = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
    localparam int CMD_IDX_W  = 3;
    localparam int POS_W      = 4;
    localparam int TOK_W      = 4;
    localparam int PIDX_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] ST_DISPATCHED = 2'd0;
    localparam logic [1:0] ST_NO_HANDLER = 2'd1;
    localparam logic [1:0] ST_UNKNOWN    = 2'd2;
    localparam logic [1:0] ST_NO_PREFIX  = 2'd3;

    localparam logic KIND_PARAM   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CMD_COUNT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_MASK = 3'd7;

    typedef enum logic [2:0] {
        PH_A          = 3'd0,
        PH_T          = 3'd1,
        PH_PLUS       = 3'd2,
        PH_NAME       = 3'd3,
        PH_ARGS       = 3'd4,
        PH_IDLE_MATCH = 3'd5,
        PH_BAD        = 3'd6,
        PH_ARGS_DONE  = 3'd7
    } t_phase;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // One record per accepted character that causes output.
    typedef struct packed {
        logic                 has_param;
        logic [7:0]           pchar;
        logic [PIDX_W-1:0]    pidx;
        logic                 has_sum;
        logic [1:0]           status;
        logic [CMD_IDX_W-1:0] cmd;
        logic [TOK_W-1:0]     total;
    } t_evt;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           pchar;
        logic [PIDX_W-1:0]    pidx;
        logic [1:0]           status;
        logic [CMD_IDX_W-1:0] cmd;
        logic [TOK_W-1:0]     total;
        logic                 last;
    } t_beat;

    function automatic logic [7:0] name_byte(input logic [NAME_W-1:0] w,
                                             input logic [NAME_IDX_W-1:0] p);
        return w[{p, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/atp_front.sv =====
module atp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  atp_pkg::t_cfg_wr i_cfg,
    input  logic            i_take,
    input  logic [7:0]      i_char,
    input  logic            i_last,
    output logic            o_wr,
    output atp_pkg::t_evt   o_evt
);

    // Configuration registers.
    logic [atp_pkg::NAME_W-1:0]    r_name [atp_pkg::NUM_COMMANDS];
    logic [2:0]                    r_cmd_count;
    logic [atp_pkg::NUM_COMMANDS-1:0] r_hmask;

    // Per-line parser state.
    atp_pkg::t_phase                  r_phase, n_phase;
    logic [atp_pkg::POS_W-1:0]        r_pos, n_pos;
    logic [atp_pkg::NUM_COMMANDS-1:0] r_sm, n_sm;
    logic [atp_pkg::CMD_IDX_W-1:0]    r_ent, n_ent;
    logic                             r_found, n_found;
    logic [atp_pkg::TOK_W-1:0]        r_tok, n_tok;
    logic                             r_in, n_in;

    logic                             adv;
    logic [atp_pkg::NUM_COMMANDS-1:0] sm1;
    logic [atp_pkg::POS_W-1:0]        pos1;
    logic [2:0]                       cnt_sat;
    logic [atp_pkg::NUM_COMMANDS-1:0] cand;
    logic                             cl_found;
    logic [atp_pkg::CMD_IDX_W-1:0]    cl_ent;
    logic                             cl_disp;
    logic                             term;
    atp_pkg::t_phase                  phase1, phase2;
    logic                             found1, found2;
    logic [atp_pkg::CMD_IDX_W-1:0]    ent1, ent2;
    logic [atp_pkg::TOK_W-1:0]        tok1;
    logic                             in1;
    logic                             par_hit;
    logic [atp_pkg::PIDX_W-1:0]       par_idx;

    assign term = (i_char == atp_pkg::CH_NUL) || (i_char == atp_pkg::CH_EQ);

    // Name compare: one more character against every entry.
    always_comb begin
        adv  = (r_phase == atp_pkg::PH_NAME) && !term;
        sm1  = r_sm;
        pos1 = r_pos;
        if (adv) begin
            for (int j = 0; j < atp_pkg::NUM_COMMANDS; j++) begin
                if ((r_pos >= atp_pkg::POS_W'(atp_pkg::NAME_CHARS)) ||
                    (atp_pkg::name_byte(r_name[j], r_pos[atp_pkg::NAME_IDX_W-1:0])
                     != i_char)) begin
                    sm1[j] = 1'b0;
                end
            end
            if (r_pos != {atp_pkg::POS_W{1'b1}}) begin
                pos1 = r_pos + 1'b1;
            end
        end
    end

    // Name close: lowest surviving entry whose name ends here.
    always_comb begin
        cnt_sat = (r_cmd_count > 3'(atp_pkg::NUM_COMMANDS)) ?
                  3'(atp_pkg::NUM_COMMANDS) : r_cmd_count;
        for (int j = 0; j < atp_pkg::NUM_COMMANDS; j++) begin
            if (pos1 >= atp_pkg::POS_W'(atp_pkg::NAME_CHARS)) begin
                cand[j] = sm1[j] && (3'(j) < cnt_sat) &&
                          (pos1 == atp_pkg::POS_W'(atp_pkg::NAME_CHARS));
            end else begin
                cand[j] = sm1[j] && (3'(j) < cnt_sat) &&
                          (atp_pkg::name_byte(r_name[j],
                                              pos1[atp_pkg::NAME_IDX_W-1:0])
                           == atp_pkg::CH_NUL);
            end
        end
        cl_found = |cand;
        cl_ent   = '0;
        for (int j = atp_pkg::NUM_COMMANDS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                cl_ent = atp_pkg::CMD_IDX_W'(j);
            end
        end
        cl_disp = cl_found && r_hmask[cl_ent];
    end

    // Next state.
    always_comb begin
        phase1  = r_phase;
        found1  = r_found;
        ent1    = r_ent;
        tok1    = r_tok;
        in1     = r_in;
        par_hit = 1'b0;
        par_idx = '0;
        case (r_phase)
            atp_pkg::PH_A: begin
                phase1 = (i_char == atp_pkg::CH_A) ? atp_pkg::PH_T : atp_pkg::PH_BAD;
            end
            atp_pkg::PH_T: begin
                phase1 = (i_char == atp_pkg::CH_T) ? atp_pkg::PH_PLUS : atp_pkg::PH_BAD;
            end
            atp_pkg::PH_PLUS: begin
                phase1 = (i_char == atp_pkg::CH_PLUS) ? atp_pkg::PH_NAME :
                         atp_pkg::PH_BAD;
            end
            atp_pkg::PH_NAME: begin
                if (term) begin
                    found1 = cl_found;
                    ent1   = cl_ent;
                    if (cl_disp) begin
                        phase1 = (i_char == atp_pkg::CH_NUL) ? atp_pkg::PH_ARGS_DONE :
                                 atp_pkg::PH_ARGS;
                    end else begin
                        phase1 = atp_pkg::PH_IDLE_MATCH;
                    end
                end
            end
            atp_pkg::PH_ARGS: begin
                if (i_char == atp_pkg::CH_NUL) begin
                    phase1 = atp_pkg::PH_ARGS_DONE;
                end else if (i_char == atp_pkg::CH_COMMA) begin
                    in1 = 1'b0;
                end else if (r_in) begin
                    par_hit = 1'b1;
                    par_idx = atp_pkg::PIDX_W'(r_tok - 1'b1);
                end else if (r_tok < atp_pkg::TOK_W'(atp_pkg::MAX_PARAMS)) begin
                    par_hit = 1'b1;
                    par_idx = atp_pkg::PIDX_W'(r_tok);
                    tok1    = r_tok + 1'b1;
                    in1     = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // A line that ends inside the name closes it here.
        phase2 = phase1;
        found2 = found1;
        ent2   = ent1;
        if (i_last && (phase1 == atp_pkg::PH_NAME)) begin
            phase2 = cl_disp ? atp_pkg::PH_ARGS_DONE : atp_pkg::PH_IDLE_MATCH;
            found2 = cl_found;
            ent2   = cl_ent;
        end

        if (i_last) begin
            n_phase = atp_pkg::PH_A;
            n_pos   = '0;
            n_sm    = '1;
            n_ent   = '0;
            n_found = 1'b0;
            n_tok   = '0;
            n_in    = 1'b0;
        end else begin
            n_phase = phase1;
            n_pos   = pos1;
            n_sm    = sm1;
            n_ent   = ent1;
            n_found = found1;
            n_tok   = tok1;
            n_in    = in1;
        end
    end

    // Record for the queue.
    always_comb begin
        o_wr            = i_take && (par_hit || i_last);
        o_evt.has_param = par_hit;
        o_evt.pchar     = i_char;
        o_evt.pidx      = par_idx;
        o_evt.has_sum   = i_last;
        o_evt.cmd       = '0;
        o_evt.total     = '0;
        case (phase2)
            atp_pkg::PH_ARGS, atp_pkg::PH_ARGS_DONE: begin
                o_evt.status = atp_pkg::ST_DISPATCHED;
                o_evt.cmd    = ent2;
                o_evt.total  = tok1;
            end
            atp_pkg::PH_IDLE_MATCH: begin
                o_evt.status = found2 ? atp_pkg::ST_NO_HANDLER : atp_pkg::ST_UNKNOWN;
                o_evt.cmd    = found2 ? ent2 : '0;
            end
            default: begin
                o_evt.status = atp_pkg::ST_NO_PREFIX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= atp_pkg::PH_A;
            r_pos   <= '0;
            r_sm    <= '1;
            r_ent   <= '0;
            r_found <= 1'b0;
            r_tok   <= '0;
            r_in    <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sm    <= n_sm;
            r_ent   <= n_ent;
            r_found <= n_found;
            r_tok   <= n_tok;
            r_in    <= n_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < atp_pkg::NUM_COMMANDS; j++) begin
                r_name[j] <= '0;
            end
            r_cmd_count <= '0;
            r_hmask     <= '0;
        end else if (i_cfg.we) begin
            if (i_cfg.index < atp_pkg::CFG_IDX_W'(atp_pkg::NUM_COMMANDS)) begin
                r_name[i_cfg.index] <= i_cfg.data[atp_pkg::NAME_W-1:0];
            end else if (i_cfg.index == atp_pkg::CFG_CMD_COUNT) begin
                r_cmd_count <= i_cfg.data[2:0];
            end else if (i_cfg.index == atp_pkg::CFG_HANDLER_MASK) begin
                r_hmask <= i_cfg.data[atp_pkg::NUM_COMMANDS-1:0];
            end
        end
    end

endmodule

// ===== rtl/atp_queue.sv =====
module atp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  atp_pkg::t_evt i_wdata,
    input  logic          i_rd,
    output logic          o_full,
    output logic          o_empty,
    output atp_pkg::t_evt o_head
);

    atp_pkg::t_evt               r_mem [atp_pkg::QDEPTH];
    logic [atp_pkg::QPTR_W-1:0]  r_wptr, r_rptr;
    logic [atp_pkg::QCNT_W-1:0]  r_cnt;
    logic                        do_wr, do_rd;

    assign o_full  = (r_cnt == atp_pkg::QCNT_W'(atp_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == atp_pkg::QPTR_W'(atp_pkg::QDEPTH - 1)) ? '0 :
                          r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == atp_pkg::QPTR_W'(atp_pkg::QDEPTH - 1)) ? '0 :
                          r_rptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/atp_back.sv =====
module atp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  atp_pkg::t_evt  i_q_head,
    output logic           o_q_rd,
    input  logic           i_pop,
    output logic           o_valid,
    output atp_pkg::t_beat o_beat
);

    logic                          r_ov;
    atp_pkg::t_beat                r_beat;
    logic                          r_pend;
    logic [1:0]                    r_pst;
    logic [atp_pkg::CMD_IDX_W-1:0] r_pcmd;
    logic [atp_pkg::TOK_W-1:0]     r_ptot;

    logic                          load;
    logic                          n_ov;
    atp_pkg::t_beat                n_beat;
    logic                          n_pend;

    assign load = !r_ov || i_pop;

    always_comb begin
        n_ov          = r_ov;
        n_beat        = r_beat;
        n_pend        = r_pend;
        o_q_rd        = 1'b0;
        if (load) begin
            n_ov = 1'b0;
            if (r_pend) begin
                n_ov          = 1'b1;
                n_pend        = 1'b0;
                n_beat.kind   = atp_pkg::KIND_SUMMARY;
                n_beat.pchar  = '0;
                n_beat.pidx   = '0;
                n_beat.status = r_pst;
                n_beat.cmd    = r_pcmd;
                n_beat.total  = r_ptot;
                n_beat.last   = 1'b1;
            end else if (!i_q_empty) begin
                n_ov   = 1'b1;
                o_q_rd = 1'b1;
                if (i_q_head.has_param) begin
                    n_pend        = i_q_head.has_sum;
                    n_beat.kind   = atp_pkg::KIND_PARAM;
                    n_beat.pchar  = i_q_head.pchar;
                    n_beat.pidx   = i_q_head.pidx;
                    n_beat.status = '0;
                    n_beat.cmd    = '0;
                    n_beat.total  = '0;
                    n_beat.last   = 1'b0;
                end else begin
                    n_beat.kind   = atp_pkg::KIND_SUMMARY;
                    n_beat.pchar  = '0;
                    n_beat.pidx   = '0;
                    n_beat.status = i_q_head.status;
                    n_beat.cmd    = i_q_head.cmd;
                    n_beat.total  = i_q_head.total;
                    n_beat.last   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_ov   <= n_ov;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
        if (o_q_rd) begin
            r_pst  <= i_q_head.status;
            r_pcmd <= i_q_head.cmd;
            r_ptot <= i_q_head.total;
        end
    end

    assign o_valid = r_ov;
    assign o_beat  = r_beat;

endmodule

// ===== rtl/at_command_line_parser.sv =====
// Channel   Direction  Handshake                Payload
// input     in         push / full              i_char_in, i_line_end
// result    out        empty / pop              o_item_kind .. o_line_last
// config    in         i_cfg_we (no stall)      i_cfg_index, i_cfg_data
//
// One character is taken every cycle while full is low; the front decides its fate
// in the same cycle. Beats pass the queue and the back's register, one per cycle
// while popped; a line end that also carries a parameter byte yields two beats.
// The four-record queue between the front and the back sets when full rises.
// Reset is synchronous; there is no clearing pass.
module at_command_line_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_in,
    input  logic        i_line_end,

    output logic        empty,
    input  logic        pop,
    output logic        o_item_kind,
    output logic [7:0]  o_param_char,
    output logic [2:0]  o_param_index,
    output logic [1:0]  o_status,
    output logic [2:0]  o_command_index,
    output logic [3:0]  o_param_total,
    output logic        o_line_last,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    atp_pkg::t_cfg_wr cfg;
    atp_pkg::t_evt    q_wdata;
    atp_pkg::t_evt    q_head;
    atp_pkg::t_beat   beat;
    logic             take;
    logic             q_wr;
    logic             q_rd;
    logic             q_full;
    logic             q_empty;
    logic             out_valid;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // A character is taken whenever the queue has room for the record it may make.
    assign full = q_full;
    assign take = push && !q_full;

    // The front walks the prefix, the name compare and the parameter split.
    atp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_take  (take),
        .i_char  (i_char_in),
        .i_last  (i_line_end),
        .o_wr    (q_wr),
        .o_evt   (q_wdata)
    );

    // Each record holds up to two beats: a parameter byte and a line summary.
    atp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The back splits records into beats and holds the current one in a register.
    atp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_rd    (q_rd),
        .i_pop     (pop && out_valid),
        .o_valid   (out_valid),
        .o_beat    (beat)
    );

    assign empty           = !out_valid;
    assign o_item_kind     = beat.kind;
    assign o_param_char    = beat.pchar;
    assign o_param_index   = beat.pidx;
    assign o_status        = beat.status;
    assign o_command_index = beat.cmd;
    assign o_param_total   = beat.total;
    assign o_line_last     = beat.last;

    // A record is never offered to a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_wr && q_full))
        else $error("record written into a full queue");

    // Every accepted line end leaves a summary record.
    a_line_end_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_line_end) |-> q_wr)
        else $error("line end accepted without a record");

    // A summary never reports more parameters than are kept.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_item_kind == atp_pkg::KIND_SUMMARY)) |->
        (o_param_total <= 4'(atp_pkg::MAX_PARAMS)))
        else $error("parameter total out of range");

    // A beat that was not taken is still shown in the next cycle.
    a_beat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(beat)))
        else $error("waiting beat changed");

endmodule
